>>> sv/pss_pkg.sv
`default_nettype none
package pss_pkg;
  localparam int QueueDepthDef = 16;
  localparam int ValueWidthDef = 32;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PRE   = 2'd1,
    OP_POST  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_SHORT   = 3'd0,
    REG_LONG    = 3'd1,
    REG_DELAY   = 3'd2,
    REG_RELEASE = 3'd3,
    REG_DCOND   = 3'd4,
    REG_DFAC    = 3'd5,
    REG_DTRACE  = 3'd6,
    REG_INITW   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] time_stamp;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] conductance;
    logic [23:0]        peak_weight_out;
    logic signed [31:0] facilitation_out;
    logic               spike_applied;
    logic               queue_overflow;
  } out_item_t;

  // classified command from front to back
  typedef struct packed {
    op_t op;
    logic due;
    logic overflow;
  } cmd_t;

  localparam logic signed [63:0] QOne  = 64'sd65536;
  localparam logic signed [63:0] QHalf = 64'sd32768;
  localparam logic signed [63:0] WLimit = 64'sd13107200;
endpackage
`default_nettype wire

>>> sv/pss_front.sv
`default_nettype none
module pss_front import pss_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire in_item_t    item,
  input  wire logic [15:0] delay,
  output cmd_t             cmd
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0]   mem [QUEUE_DEPTH];
  logic [AW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r;
  logic [31:0]   head_val_r;
  logic          full, due;

  assign full = (count_r == CW'(QUEUE_DEPTH));
  // head entry is read through a register; accepted items never arrive back to back
  assign due = (count_r != '0) &&
               ({1'b0, item.time_stamp} > ({1'b0, head_val_r} + 33'(delay)));

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
    if (32'(a) == QUEUE_DEPTH - 1) return '0;
    return a + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (go && op_t'(item.op) == OP_PRE && !full) mem[tail_r] <= item.time_stamp;
    head_val_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
    end else if (go) begin
      unique case (op_t'(item.op))
        OP_TICK: if (due) begin
          head_r <= inc(head_r);
          count_r <= count_r - CW'(1);
        end
        OP_PRE: if (!full) begin
          tail_r <= inc(tail_r);
          count_r <= count_r + CW'(1);
        end
        OP_POST: ;
        OP_CLEAR: begin
          head_r <= '0;
          tail_r <= '0;
          count_r <= '0;
        end
        default: ;
      endcase
    end
  end

  assign cmd.op = op_t'(item.op);
  assign cmd.due = (op_t'(item.op) == OP_TICK) && due;
  assign cmd.overflow = (op_t'(item.op) == OP_PRE) && full;
endmodule
`default_nettype wire

>>> sv/pss_back.sv
`default_nettype none
module pss_back import pss_pkg::*; #(
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire cmd_t        cmd,
  input  wire logic        short_on,
  input  wire logic        long_on,
  input  wire logic [16:0] release_f,
  input  wire logic [16:0] dcond,
  input  wire logic [16:0] dfac,
  input  wire logic [16:0] dtrace,
  input  wire logic [23:0] initw,
  output logic             busy,
  output logic             done,
  output out_item_t        res
);
  localparam int VW = (VALUE_WIDTH > 38) ? 38 : VALUE_WIDTH;
  localparam int PW = VW + 26;
  localparam logic signed [63:0] VMax = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] VMin = -VMax - 64'sd1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_DEC1 = 5'b00010, S_DEC2 = 5'b00100,
    S_APP1 = 5'b01000, S_APP2 = 5'b10000
  } st_t;

  st_t st_r;
  cmd_t cmd_r;
  logic signed [63:0] g_r, f_r, pre_r, post_r, w_r, tmp_r;
  logic done_r;

  function automatic logic signed [63:0] sat(input logic signed [63:0] v);
    if (v > VMax) return VMax;
    if (v < VMin) return VMin;
    return v;
  endfunction

  function automatic logic signed [63:0] clw(input logic signed [63:0] v);
    if (v < 0) return 64'sd0;
    if (v > WLimit) return WLimit;
    return v;
  endfunction

  // floor((a*b + half) / 65536) equals the round-to-nearest, ties up
  function automatic logic signed [63:0] qmul(input logic signed [VW:0] a,
                                              input logic signed [24:0] b);
    logic signed [PW-1:0] p;
    p = a * b + PW'(QHalf);
    return sat(64'(p >>> 16));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done_r <= 1'b0;
      g_r <= '0; f_r <= QOne; pre_r <= '0; post_r <= '0; w_r <= QOne;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (start) begin
          cmd_r <= cmd;
          unique case (cmd.op)
            OP_TICK: st_r <= S_DEC1;
            OP_PRE: done_r <= 1'b1;
            OP_POST: begin
              if (long_on) begin
                post_r <= sat(post_r - 2 * QOne);
                w_r <= clw(w_r + qmul((VW+1)'(pre_r), 25'(QHalf)));
              end
              done_r <= 1'b1;
            end
            OP_CLEAR: begin
              g_r <= '0; f_r <= QOne; pre_r <= '0; post_r <= '0;
              w_r <= clw(64'(initw));
              done_r <= 1'b1;
            end
            default: ;
          endcase
        end
        S_DEC1: begin
          g_r <= qmul((VW+1)'(g_r), 25'(dcond));
          if (short_on) f_r <= sat(QOne + qmul((VW+1)'(f_r - QOne), 25'(dfac)));
          if (long_on) pre_r <= qmul((VW+1)'(pre_r), 25'(dtrace));
          st_r <= S_DEC2;
        end
        S_DEC2: begin
          if (long_on) post_r <= qmul((VW+1)'(post_r), 25'(dtrace));
          if (cmd_r.due) begin
            tmp_r <= short_on ? qmul((VW+1)'(f_r), 25'(w_r)) : w_r;
            st_r <= S_APP1;
          end else begin
            done_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        S_APP1: begin
          g_r <= sat(g_r + tmp_r);
          if (short_on) f_r <= qmul((VW+1)'(f_r), 25'(release_f));
          if (long_on) pre_r <= sat(pre_r + QOne);
          tmp_r <= qmul((VW+1)'(post_r), 25'(QHalf));
          st_r <= S_APP2;
        end
        S_APP2: begin
          if (long_on) w_r <= clw(w_r + tmp_r);
          done_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (st_r != S_IDLE) || done_r;
  assign done = done_r;
  assign res.conductance = g_r[31:0];
  assign res.peak_weight_out = w_r[23:0];
  assign res.facilitation_out = f_r[31:0];
  assign res.spike_applied = cmd_r.due;
  assign res.queue_overflow = cmd_r.overflow;
endmodule
`default_nettype wire

>>> sv/plastic_synapse_step.sv
// path: an accepted item is registered into the command queue, the back end takes it,
// and its result is registered at the output; a tick also passes S_DEC1 and S_DEC2,
// and a tick that applies a spike then S_APP1 and S_APP2; one item in flight, the next
// is accepted only once the last result has left, so out_stall holds the flow
// reset: synchronous active-low, restores registers, traces and an empty queue
`default_nettype none
module plastic_synapse_step import pss_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  logic        short_r, long_r;
  logic [15:0] delay_r;
  logic [16:0] rel_r, dcond_r, dfac_r, dtrace_r;
  logic [23:0] initw_r;

  // one-entry command queue between front and back
  cmd_t q_r;
  logic q_v_r;
  cmd_t fcmd;
  logic in_go, b_start, b_busy, b_done;
  out_item_t b_res;
  logic busy_r; // an item is somewhere between accept and output

  assign cfg_ready = 1'b1;
  assign in_stall = busy_r;
  assign in_go = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= 1'b0; long_r <= 1'b0; delay_r <= 16'd1280;
      rel_r <= 17'd39322; dcond_r <= 17'd52429; dfac_r <= 17'd65536;
      dtrace_r <= 17'd62259; initw_r <= 24'd65536;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SHORT:   short_r <= cfg_data[0];
        REG_LONG:    long_r <= cfg_data[0];
        REG_DELAY:   delay_r <= cfg_data[15:0];
        REG_RELEASE: rel_r <= cfg_data[16:0];
        REG_DCOND:   dcond_r <= cfg_data[16:0];
        REG_DFAC:    dfac_r <= cfg_data[16:0];
        REG_DTRACE:  dtrace_r <= cfg_data[16:0];
        REG_INITW:   initw_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pss_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .go(in_go), .item(in_data), .delay(delay_r), .cmd(fcmd)
  );

  assign b_start = q_v_r && !b_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) q_v_r <= 1'b0;
    else if (in_go) q_v_r <= 1'b1;
    else if (b_start) q_v_r <= 1'b0;
    if (in_go) q_r <= fcmd;
  end

  pss_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst_n, .start(b_start), .cmd(q_r), .short_on(short_r),
    .long_on(long_r), .release_f(rel_r), .dcond(dcond_r), .dfac(dfac_r),
    .dtrace(dtrace_r), .initw(initw_r), .busy(b_busy), .done(b_done),
    .res(b_res)
  );

  // output register, holds while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      if (b_done) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (in_go) busy_r <= 1'b1;
      else if (out_valid && !out_stall) busy_r <= 1'b0;
    end
    if (b_done) out_data <= b_res;
  end

  a_no_new_during_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |=> !in_go) else $error("item accepted while busy");
  a_done_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    b_done |-> busy_r) else $error("result without item");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.spike_applied && out_data.queue_overflow))
    else $error("both flags set");
endmodule
`default_nettype wire

>>> test/tb_plastic_synapse_step.sv
module tb_plastic_synapse_step;
  import pss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ValMax = 64'sd2147483647;
  localparam longint ValMin = -64'sd2147483648;
  localparam int DepthQ = 16;
  // cycles with no transfer anywhere before the run is declared hung
  localparam int HangLimit = 6000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  plastic_synapse_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the synapse registers and state
  bit stp_on, stdp_on;
  int unsigned delay_q, release_q, dcond_q, dfac_q, dtrace_q, initw_q;
  longint cond_s, fac_s, pre_tr_s, post_tr_s, weight_s;
  int unsigned spike_ring[DepthQ];
  int unsigned ring_count, ring_head;

  in_item_t pending_items[$];
  out_item_t synapse_results_due[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit in_took = 1'b0;
  int errors = 0;
  int n_items = 0, n_results = 0, n_applied = 0, n_dropped = 0, n_cfg = 0;
  int quiet_cycles = 0;
  int unsigned sim_now;

  task automatic enqueue_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_expected(out_item_t r);
    synapse_results_due.insert(synapse_results_due.size(), r);
  endtask

  function automatic longint clip_value(longint v);
    if (v > ValMax) return ValMax;
    if (v < ValMin) return ValMin;
    return v;
  endfunction

  function automatic longint clip_weight(longint v);
    if (v < 0) return 0;
    if (v > 64'sd13107200) return 64'sd13107200;
    return v;
  endfunction

  // q16.16 product, round half up (floor after adding half), saturated
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b + 64'sd32768;
    return clip_value(p >>> 16);
  endfunction

  task automatic clear_synapse();
    cond_s = 0;
    fac_s = 65536;
    pre_tr_s = 0;
    post_tr_s = 0;
    ring_count = 0;
    ring_head = 0;
  endtask

  task automatic reset_synapse();
    stp_on = 0; stdp_on = 0;
    delay_q = 1280; release_q = 39322; dcond_q = 52429;
    dfac_q = 65536; dtrace_q = 62259; initw_q = 65536;
    clear_synapse();
    weight_s = 65536;
  endtask

  task automatic load_register(reg_idx_t idx, logic [23:0] v);
    case (idx)
      REG_SHORT:   stp_on = v[0];
      REG_LONG:    stdp_on = v[0];
      REG_DELAY:   delay_q = v[15:0];
      REG_RELEASE: release_q = v[16:0];
      REG_DCOND:   dcond_q = v[16:0];
      REG_DFAC:    dfac_q = v[16:0];
      REG_DTRACE:  dtrace_q = v[16:0];
      REG_INITW:   initw_q = v;
      default: ;
    endcase
  endtask

  // advance the synapse by one item and queue the result it must produce
  task automatic step_synapse(in_item_t it);
    out_item_t r;
    bit applied, dropped;
    longint unsigned due;
    applied = 0;
    dropped = 0;
    case (op_t'(it.op))
      OP_TICK: begin
        cond_s = fx_mul(cond_s, dcond_q);
        if (stp_on) fac_s = clip_value(65536 + fx_mul(fac_s - 65536, dfac_q));
        if (stdp_on) begin
          pre_tr_s = fx_mul(pre_tr_s, dtrace_q);
          post_tr_s = fx_mul(post_tr_s, dtrace_q);
        end
        if (ring_count != 0) begin
          // due time is compared in full width, no wrap
          due = longint'(spike_ring[ring_head]) + longint'(delay_q);
          if (longint'(it.time_stamp) > due) begin
            applied = 1;
            ring_head = (ring_head + 1) % DepthQ;
            ring_count--;
            if (stp_on) begin
              cond_s = clip_value(cond_s + fx_mul(fac_s, weight_s));
              fac_s = fx_mul(fac_s, release_q);
            end else begin
              cond_s = clip_value(cond_s + weight_s);
            end
            if (stdp_on) begin
              pre_tr_s = clip_value(pre_tr_s + 65536);
              weight_s = clip_weight(weight_s + fx_mul(post_tr_s, 32768));
            end
          end
        end
      end
      OP_PRE: begin
        if (ring_count >= DepthQ) begin
          dropped = 1;
        end else begin
          spike_ring[(ring_head + ring_count) % DepthQ] = it.time_stamp;
          ring_count++;
        end
      end
      OP_POST: begin
        if (stdp_on) begin
          post_tr_s = clip_value(post_tr_s - 131072);
          weight_s = clip_weight(weight_s + fx_mul(pre_tr_s, 32768));
        end
      end
      default: begin
        clear_synapse();
        weight_s = clip_weight(initw_q);
      end
    endcase
    r.conductance = cond_s[31:0];
    r.peak_weight_out = weight_s[23:0];
    r.facilitation_out = fac_s[31:0];
    r.spike_applied = applied;
    r.queue_overflow = dropped;
    n_applied += applied;
    n_dropped += dropped;
    add_expected(r);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: new payload only when the previous one was taken or none is up
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        step_synapse(in_data);
        n_items++;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (synapse_results_due.size() == 0) begin
          report_mismatch("unexpected result", longint'(out_data.conductance), 64'sd0);
        end else begin
          want = synapse_results_due.pop_front();
          if (out_data.conductance !== want.conductance)
            report_mismatch("conductance", longint'(out_data.conductance),
                            longint'(want.conductance));
          if (out_data.peak_weight_out !== want.peak_weight_out)
            report_mismatch("peak_weight", longint'(out_data.peak_weight_out),
                            longint'(want.peak_weight_out));
          if (out_data.facilitation_out !== want.facilitation_out)
            report_mismatch("facilitation", longint'(out_data.facilitation_out),
                            longint'(want.facilitation_out));
          if (out_data.spike_applied !== want.spike_applied)
            report_mismatch("spike_applied", longint'(out_data.spike_applied),
                            longint'(want.spike_applied));
          if (out_data.queue_overflow !== want.queue_overflow)
            report_mismatch("queue_overflow", longint'(out_data.queue_overflow),
                            longint'(want.queue_overflow));
        end
      end
      // hang watchdog: any transfer on any channel resets it
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HangLimit) begin
        $display("watchdog: no transfer for %0d cycles", HangLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_register(reg_idx_t idx, logic [23:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    load_register(idx, v);
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_item_t make_item(op_t op, logic [31:0] ts);
    in_item_t it;
    it.op = op;
    it.time_stamp = ts;
    return it;
  endfunction

  // let every queued item through and every result out, then a short pause
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || synapse_results_due.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [23:0] pick(logic [23:0] lo, logic [23:0] hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return 24'($urandom_range(32'(lo), 32'(hi)));
    endcase
  endfunction

  // mostly coherent spike trains over a running time base, some noise
  task automatic queue_random(int n);
    int k;
    int unsigned step;
    sim_now = $urandom_range(0, 32'h7fff_0000);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 10) begin
        enqueue_item(make_item(op_t'($urandom_range(0, 3)), $urandom()));
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:44]: begin
            step = $urandom_range(0, (delay_q >> 2) + 300);
            sim_now += step;
            enqueue_item(make_item(OP_TICK, sim_now));
          end
          [45:74]: enqueue_item(make_item(OP_PRE, sim_now + $urandom_range(0, 64)));
          [75:96]: enqueue_item(make_item(OP_POST, $urandom()));
          default: enqueue_item(make_item(OP_CLEAR, $urandom()));
        endcase
      end
    end
  endtask

  initial begin
    int ph, k;
    reset_synapse();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: both plasticity paths on, short delay, weight at the ceiling
    write_register(REG_SHORT, 24'd1);
    write_register(REG_LONG, 24'd1);
    write_register(REG_DELAY, 24'd16);
    write_register(REG_INITW, 24'hffffff);
    enqueue_item(make_item(OP_CLEAR, 32'd0));
    enqueue_item(make_item(OP_PRE, 32'd0));
    enqueue_item(make_item(OP_TICK, 32'd0));
    enqueue_item(make_item(OP_TICK, 32'd16));
    enqueue_item(make_item(OP_TICK, 32'd17));
    enqueue_item(make_item(OP_POST, 32'hffffffff));
    enqueue_item(make_item(OP_POST, 32'd0));
    // queue full: the seventeenth spike is dropped
    for (k = 0; k < 17; k++)
      enqueue_item(make_item(OP_PRE, 32'hffffffef));
    enqueue_item(make_item(OP_TICK, 32'hffffffff));
    enqueue_item(make_item(OP_CLEAR, 32'hffffffff));
    drain();

    for (ph = 1; ph <= 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      write_register(REG_SHORT, 24'(ph[0]));
      write_register(REG_LONG, 24'(ph[1] | ph[2]));
      write_register(REG_DELAY, pick(24'd0, 24'd65535));
      write_register(REG_RELEASE, pick(24'd0, 24'd131071));
      write_register(REG_DCOND, pick(24'd0, 24'd131071));
      write_register(REG_DFAC, pick(24'd0, 24'd131071));
      write_register(REG_DTRACE, pick(24'd0, 24'd131071));
      write_register(REG_INITW, pick(24'd0, 24'hffffff));
      queue_random(225);
      drain();
    end

    $display("covered %0d items, %0d results, %0d register writes", n_items, n_results, n_cfg);
    $display("spikes applied %0d, spikes dropped on full queue %0d, mismatches %0d",
             n_applied, n_dropped, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> files.f
sv/pss_pkg.sv
sv/pss_front.sv
sv/pss_back.sv
sv/plastic_synapse_step.sv
test/tb_plastic_synapse_step.sv
